@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/cte_pkg.sv @@
// Constants, tables and helper functions for the calendar to timestamp block.
`default_nettype none

package cte_pkg;

    localparam int unsigned TS_W   = 52;
    localparam int unsigned SECS_W = 32;
    localparam int unsigned REM_W  = 20;

    localparam logic [1:0] MODE_MS = 2'd1;
    localparam logic [1:0] MODE_US = 2'd2;

    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;

    localparam logic [REM_W-1:0] MS_PER_S = 20'd1000;
    localparam logic [REM_W-1:0] US_PER_S = 20'd1000000;

    // Reciprocals for the fraction reduction: floor(2^41/1000) and floor(2^50/1e6).
    localparam logic [31:0] RECIP_MS = 32'd2199023255;
    localparam logic [31:0] RECIP_US = 32'd1125899906;
    localparam int unsigned MS_SHIFT = 41;
    localparam int unsigned US_SHIFT = 50;

    // Days in the months before the indexed month of a common year.
    localparam logic [8:0] DAYS_BEFORE [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
    };

    function automatic logic [REM_W-1:0] unit_scale(input logic [1:0] mode);
        logic [REM_W-1:0] scale;
        case (mode)
            MODE_MS: scale = MS_PER_S;
            MODE_US: scale = US_PER_S;
            default: scale = 20'd1;
        endcase
        return scale;
    endfunction

    function automatic logic [REM_W-1:0] frac_modulus(input logic [1:0] mode);
        return (mode == MODE_US) ? US_PER_S : MS_PER_S;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cte_ifs.sv @@
// Valid/ready channel interfaces for the calendar input and the timestamp output.
`default_nettype none

interface cte_cal_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [6:0]  year_offset;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] fraction_count;

    modport source (
        output valid, mode, year_offset, month, day_of_month, hour, minute, second,
               fraction_count,
        input  ready
    );
    modport sink (
        input  valid, mode, year_offset, month, day_of_month, hour, minute, second,
               fraction_count,
        output ready
    );
endinterface

interface cte_ts_if;
    logic        valid;
    logic        ready;
    logic [51:0] timestamp;
    logic        bad_input;

    modport source (output valid, timestamp, bad_input, input ready);
    modport sink (input valid, timestamp, bad_input, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cte_date_secs.sv @@
// Two pipeline stages that turn a calendar reading into whole seconds since 2000.
`default_nettype none

module cte_date_secs
    import cte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [6:0]        i_year,
    input  wire logic [3:0]        i_month,
    input  wire logic [4:0]        i_day,
    input  wire logic [4:0]        i_hour,
    input  wire logic [5:0]        i_minute,
    input  wire logic [5:0]        i_second,
    output      logic [SECS_W-1:0] o_secs,
    output      logic              o_bad
);

    logic [15:0]       w_y365;
    logic [4:0]        w_yquads;
    logic              w_leap;
    logic [15:0]       n_days;
    logic [16:0]       n_sod;
    logic              n_bad;
    logic [15:0]       r_days;
    logic [16:0]       r_sod;
    logic              r_bad1;
    logic [SECS_W-1:0] r_secs;
    logic              r_bad2;

    // Leap days before year y: (y + 3) / 4, since every fourth year from 2000 is leap.
    always_comb begin
        w_y365   = 16'(i_year) * DAYS_PER_YEAR;
        w_yquads = 5'((8'(i_year) + 8'd3) >> 2);
        w_leap   = (i_year[1:0] == 2'b00) && (i_month > 4'd2);
        n_days   = w_y365 + 16'(w_yquads) + 16'(DAYS_BEFORE[i_month]) + 16'(w_leap)
                 + 16'(i_day) - 16'd1;
        n_sod    = 17'(i_hour) * SECS_PER_HOUR + 17'(i_minute) * SECS_PER_MIN
                 + 17'(i_second);
        n_bad    = (i_year > 7'd99) || (i_month == 4'd0) || (i_month > 4'd12)
                 || (i_day == 5'd0) || (i_hour > 5'd23) || (i_minute > 6'd59)
                 || (i_second > 6'd59);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days <= n_days;
            r_sod  <= n_sod;
            r_bad1 <= n_bad;
            r_secs <= 32'(r_days) * SECS_PER_DAY + 32'(r_sod);
            r_bad2 <= r_bad1;
        end
    end

    assign o_secs = r_secs;
    assign o_bad  = r_bad2;

endmodule

`default_nettype wire

@@ hw/rtl/cte_frac_mod.sv @@
// Three pipeline stages: fraction count modulo 1000 or 1000000, else zero.
`default_nettype none

module cte_frac_mod
    import cte_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [1:0]       i_mode,
    input  wire logic [31:0]      i_frac,
    output      logic [REM_W-1:0] o_rem
);

    logic [63:0]      r_prod;
    logic [31:0]      r_frac1;
    logic [1:0]       r_mode1;
    logic [22:0]      w_quot;
    logic [REM_W-1:0] w_div1;
    logic [42:0]      w_qd_full;
    logic [31:0]      r_qd;
    logic [31:0]      r_frac2;
    logic [1:0]       r_mode2;
    logic [31:0]      w_diff;
    logic [31:0]      w_div2;
    logic [31:0]      w_fix;
    logic [REM_W-1:0] n_rem;
    logic [REM_W-1:0] r_rem;

    // The reciprocal estimate is the true quotient or one below it.
    always_comb begin
        w_quot    = (r_mode1 == MODE_US) ? 23'(r_prod >> US_SHIFT) : 23'(r_prod >> MS_SHIFT);
        w_div1    = frac_modulus(r_mode1);
        w_qd_full = 43'(w_quot) * 43'(w_div1);
        w_diff    = r_frac2 - r_qd;
        w_div2    = 32'(frac_modulus(r_mode2));
        w_fix     = (w_diff >= w_div2) ? (w_diff - w_div2) : w_diff;
        n_rem     = ((r_mode2 == MODE_MS) || (r_mode2 == MODE_US)) ? REM_W'(w_fix) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= 64'(i_frac) * 64'((i_mode == MODE_US) ? RECIP_US : RECIP_MS);
            r_frac1 <= i_frac;
            r_mode1 <= i_mode;
            r_qd    <= w_qd_full[31:0];
            r_frac2 <= r_frac1;
            r_mode2 <= r_mode1;
            r_rem   <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

@@ hw/rtl/calendar_to_epoch_timestamp.sv @@
// Four register stages; an accepted reading moves through stages one to three to the output.
// Throughput: one reading per cycle; the whole pipe advances on one enable and holds on stall.
// The enable is low only while a finished result waits at the output and is not taken.
// Reset: i_rst_n is synchronous and active low; it clears every stage valid bit.
// Payload registers are not reset. The block has no state beyond the pipeline.
`default_nettype none

module calendar_to_epoch_timestamp
    import cte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cte_cal_if.sink   i_cal,
    cte_ts_if.source  o_ts
);

    // Pipeline advance. The output register is the last stage, so a new
    // reading is taken whenever the output slot is empty or being drained.
    logic w_en;

    // Stage valid bits travel alongside the data in every stage.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_ovld;

    // The mode is carried to stage three, where it chooses the unit scale.
    logic [1:0] r_mode1;
    logic [1:0] r_mode2;

    logic [SECS_W-1:0] w_secs;
    logic              w_bad;
    logic [REM_W-1:0]  w_rem;

    logic [TS_W-1:0] n_scaled;
    logic [TS_W-1:0] r_scaled;
    logic            r_bad3;
    logic [TS_W-1:0] n_ts;
    logic [TS_W-1:0] r_ts;
    logic            r_bad;

    assign w_en        = !r_ovld || o_ts.ready;
    assign i_cal.ready = w_en;

    // Stages one and two: day count and seconds of the day, then whole seconds.
    cte_date_secs u_date_secs (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_year   (i_cal.year_offset),
        .i_month  (i_cal.month),
        .i_day    (i_cal.day_of_month),
        .i_hour   (i_cal.hour),
        .i_minute (i_cal.minute),
        .i_second (i_cal.second),
        .o_secs   (w_secs),
        .o_bad    (w_bad)
    );

    // Stages one to three: the sub-second remainder, lined up with stage three.
    cte_frac_mod u_frac_mod (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mode (i_cal.mode),
        .i_frac (i_cal.fraction_count),
        .o_rem  (w_rem)
    );

    // Stage three scales seconds to the selected unit; the largest valid value
    // in microseconds stays below 2^52, so no bits are lost. Stage four adds
    // the remainder and forces zero for a reading flagged as out of range.
    always_comb begin
        n_scaled = 52'(w_secs) * 52'(unit_scale(r_mode2));
        n_ts     = r_bad3 ? '0 : (r_scaled + 52'(w_rem));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_v1   <= i_cal.valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_ovld <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode1  <= i_cal.mode;
            r_mode2  <= r_mode1;
            r_scaled <= n_scaled;
            r_bad3   <= w_bad;
            r_ts     <= n_ts;
            r_bad    <= r_bad3;
        end
    end

    assign o_ts.valid     = r_ovld;
    assign o_ts.timestamp = r_ts;
    assign o_ts.bad_input = r_bad;

endmodule

`default_nettype wire

@@ hw/rtl/cte_checker.sv @@
// Port-level checks for the calendar to timestamp block and their bind.
`default_nettype none
`include "assert_macros.svh"

module cte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [51:0] i_timestamp,
    input wire logic        i_bad_input
);

    // A flagged reading always carries a zero timestamp.
    `ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_bad_input, i_timestamp == 52'd0)

    // The input side never stalls while the output side is taking results.
    `ASSERT_IMPL(a_ready_pass, i_clk, i_rst_n, i_out_ready, i_in_ready)

    // The only reason to refuse input is a held result at the output.
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // A result that is not taken stays put.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_timestamp) && $stable(i_bad_input))

    logic w_unused;
    assign w_unused = i_in_valid;

endmodule

bind calendar_to_epoch_timestamp cte_checker u_cte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cal.valid),
    .i_in_ready  (i_cal.ready),
    .i_out_valid (o_ts.valid),
    .i_out_ready (o_ts.ready),
    .i_timestamp (o_ts.timestamp),
    .i_bad_input (o_ts.bad_input)
);

`default_nettype wire

@@ tb/timestamp_checker.sv @@
// Checker that predicts and compares every timestamp produced by the calendar conversion.
`timescale 1ns / 1ps

module timestamp_checker
    import cte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cte_cal_if   i_cal_mon,
    cte_ts_if    i_ts_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint unsigned SECONDS_PER_DAY    = 86400;
    localparam longint unsigned SECONDS_PER_HOUR   = 3600;
    localparam longint unsigned SECONDS_PER_MINUTE = 60;
    localparam longint unsigned MILLIS_PER_SECOND  = 1000;
    localparam longint unsigned MICROS_PER_SECOND  = 1000000;

    // Length of each month of a common year, indexed by month number.
    localparam int unsigned MONTH_LENGTH [13] = '{
        0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    typedef struct {
        logic [51:0] timestamp;
        logic        bad_input;
    } t_timestamp;

    t_timestamp awaited_stamps [$];
    int         mismatches = 0;

    function automatic t_timestamp convert_reading(
        input logic [1:0]  mode,
        input logic [6:0]  year_offset,
        input logic [3:0]  month,
        input logic [4:0]  day_of_month,
        input logic [4:0]  hour,
        input logic [5:0]  minute,
        input logic [5:0]  second,
        input logic [31:0] fraction_count
    );
        t_timestamp      stamp;
        longint unsigned days;
        longint unsigned elapsed;
        int unsigned     m;
        stamp.bad_input = (year_offset > 99) || (month < 1) || (month > 12) ||
                          (day_of_month < 1) || (hour > 23) || (minute > 59) ||
                          (second > 59);
        stamp.timestamp = '0;
        if (!stamp.bad_input) begin
            // Whole years, then one leap day for each leap year already passed.
            days = 365 * longint'(year_offset) + (longint'(year_offset) + 3) / 4;
            for (m = 1; m < month; m++) begin
                days += MONTH_LENGTH[m];
            end
            if (year_offset[1:0] == 2'b00 && month > 2) begin
                days += 1;
            end
            days += longint'(day_of_month) - 1;
            elapsed = days * SECONDS_PER_DAY + longint'(hour) * SECONDS_PER_HOUR +
                      longint'(minute) * SECONDS_PER_MINUTE + longint'(second);
            if (mode == MODE_MS) begin
                elapsed = elapsed * MILLIS_PER_SECOND +
                          longint'(fraction_count) % MILLIS_PER_SECOND;
            end else if (mode == MODE_US) begin
                elapsed = elapsed * MICROS_PER_SECOND +
                          longint'(fraction_count) % MICROS_PER_SECOND;
            end
            stamp.timestamp = elapsed[51:0];
        end
        return stamp;
    endfunction

    task automatic note_mismatch(input string what, input logic [51:0] want,
                                 input logic [51:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : compare_stamps
        t_timestamp want;
        if (i_rst_n) begin
            if (i_ts_mon.valid && i_ts_mon.ready) begin
                if (awaited_stamps.size() == 0) begin
                    note_mismatch("unexpected result timestamp", '0, i_ts_mon.timestamp);
                end else begin
                    want = awaited_stamps.pop_front();
                    if (i_ts_mon.timestamp !== want.timestamp) begin
                        note_mismatch("timestamp", want.timestamp, i_ts_mon.timestamp);
                    end
                    if (i_ts_mon.bad_input !== want.bad_input) begin
                        note_mismatch("bad_input", 52'(want.bad_input),
                                      52'(i_ts_mon.bad_input));
                    end
                end
            end
            if (i_cal_mon.valid && i_cal_mon.ready) begin
                awaited_stamps.push_back(convert_reading(
                    i_cal_mon.mode, i_cal_mon.year_offset, i_cal_mon.month,
                    i_cal_mon.day_of_month, i_cal_mon.hour, i_cal_mon.minute,
                    i_cal_mon.second, i_cal_mon.fraction_count));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_stamps.size();
    end

endmodule

@@ tb/calendar_to_epoch_timestamp_tb.sv @@
// Top of the calendar to timestamp testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module calendar_to_epoch_timestamp_tb;
    import cte_pkg::*;

    // The package names only the scaled modes; seconds and the spare code live here.
    localparam logic [1:0] MODE_SEC   = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_READINGS = 1450;
    // The last stretch of the random part runs with no idling on either side.
    localparam int QUIET_TAIL      = 200;
    // The slowest correct run is about 1500 readings with the longest idle bursts on
    // each side plus the pipeline; the limit leaves wide margin.
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet_tail = 1'b0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending_count;

    cte_cal_if cal_ch ();
    cte_ts_if  ts_ch ();

    calendar_to_epoch_timestamp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal_ch),
        .o_ts    (ts_ch)
    );

    timestamp_checker stamp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cal_mon    (cal_ch),
        .i_ts_mon     (ts_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The result side takes results freely for a while, then sometimes stalls
    // for a short burst. Once the quiet tail starts it never stalls again.
    initial begin
        ts_ch.ready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                ts_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                ts_ch.ready <= 1'b1;
            end
        end
    end

    // Drives one calendar reading and returns at the edge where it transfers.
    // Before the reading the sender may idle for a random burst, which drops
    // valid; back-to-back readings keep valid high without touching it.
    task automatic send_reading(
        input logic [1:0]  mode,
        input logic [6:0]  year_offset,
        input logic [3:0]  month,
        input logic [4:0]  day_of_month,
        input logic [4:0]  hour,
        input logic [5:0]  minute,
        input logic [5:0]  second,
        input logic [31:0] fraction_count
    );
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            cal_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        cal_ch.valid          <= 1'b1;
        cal_ch.mode           <= mode;
        cal_ch.year_offset    <= year_offset;
        cal_ch.month          <= month;
        cal_ch.day_of_month   <= day_of_month;
        cal_ch.hour           <= hour;
        cal_ch.minute         <= minute;
        cal_ch.second         <= second;
        cal_ch.fraction_count <= fraction_count;
        @(posedge i_clk);
        while (!cal_ch.ready) @(posedge i_clk);
    endtask

    // Waits until every reading sent so far has produced its result. The
    // pending count is updated with a nonblocking assignment, so the first
    // edge lets the latest transfer show up in it.
    task automatic wait_for_results();
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed readings with random content, some with one field
    // pushed out of range, and a few that are pure noise across every bit.
    task automatic send_random_reading();
        int unsigned   flavor;
        logic [1:0]    mode;
        logic [6:0]    year_offset;
        logic [3:0]    month;
        logic [4:0]    day_of_month;
        logic [4:0]    hour;
        logic [5:0]    minute;
        logic [5:0]    second;
        flavor       = $urandom_range(0, 99);
        mode         = 2'($urandom_range(0, 3));
        year_offset  = 7'($urandom_range(0, 99));
        month        = 4'($urandom_range(1, 12));
        day_of_month = 5'($urandom_range(1, 31));
        hour         = 5'($urandom_range(0, 23));
        minute       = 6'($urandom_range(0, 59));
        second       = 6'($urandom_range(0, 59));
        // Lean on the ends of the year range now and then.
        if ($urandom_range(0, 9) == 0) begin
            year_offset = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd99;
        end
        if (flavor >= 95) begin
            year_offset  = 7'($urandom);
            month        = 4'($urandom);
            day_of_month = 5'($urandom);
            hour         = 5'($urandom);
            minute       = 6'($urandom);
            second       = 6'($urandom);
        end else if (flavor >= 85) begin
            case ($urandom_range(0, 5))
                0:       year_offset  = 7'($urandom_range(100, 127));
                1:       month        = ($urandom_range(0, 1) == 0) ?
                                        4'd0 : 4'($urandom_range(13, 15));
                2:       day_of_month = 5'd0;
                3:       hour         = 5'($urandom_range(24, 31));
                4:       minute       = 6'($urandom_range(60, 63));
                default: second       = 6'($urandom_range(60, 63));
            endcase
        end
        send_reading(mode, year_offset, month, day_of_month, hour, minute, second,
                     $urandom);
    endtask

    initial begin : stimulus
        logic [1:0] every_mode [4];
        every_mode = '{MODE_SEC, MODE_MS, MODE_US, MODE_SPARE};

        cal_ch.valid          <= 1'b0;
        cal_ch.mode           <= MODE_SEC;
        cal_ch.year_offset    <= '0;
        cal_ch.month          <= '0;
        cal_ch.day_of_month   <= '0;
        cal_ch.hour           <= '0;
        cal_ch.minute         <= '0;
        cal_ch.second         <= '0;
        cal_ch.fraction_count <= '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Latest valid reading in every mode, the spare mode included. In
        // microseconds this gives the largest whole-second part the block can produce.
        foreach (every_mode[i]) begin
            send_reading(every_mode[i], 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                         32'hFFFF_FFFF);
        end
        // The epoch itself, and the fraction right at its wrap points.
        send_reading(MODE_US,  7'd0, 4'd1, 5'd1,  5'd0,  6'd0,  6'd0,  32'd0);
        send_reading(MODE_MS,  7'd0, 4'd1, 5'd1,  5'd0,  6'd0,  6'd0,  32'd999);
        send_reading(MODE_US,  7'd0, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30, 32'd999999);
        send_reading(MODE_MS,  7'd0, 4'd3, 5'd1,  5'd0,  6'd0,  6'd0,  32'd1000);
        send_reading(MODE_US,  7'd1, 4'd3, 5'd1,  5'd0,  6'd0,  6'd0,  32'd1000000);
        // Leap day in a later leap year, and a day beyond the end of February.
        send_reading(MODE_SEC, 7'd4, 4'd2, 5'd29, 5'd0,  6'd0,  6'd0,  32'd5);
        send_reading(MODE_MS,  7'd3, 4'd2, 5'd30, 5'd1,  6'd2,  6'd3,  32'd123456);
        send_reading(MODE_SEC, 7'd96, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0);
        // Each calendar field just outside its range, and all but the day at its all-ones value.
        send_reading(MODE_US,  7'd100, 4'd6, 5'd15, 5'd10, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_MS,  7'd127, 4'd6, 5'd15, 5'd10, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_US,  7'd20, 4'd0,  5'd15, 5'd10, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_SEC, 7'd20, 4'd13, 5'd15, 5'd10, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_MS,  7'd20, 4'd15, 5'd15, 5'd10, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_US,  7'd20, 4'd6,  5'd0,  5'd10, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_US,  7'd20, 4'd6,  5'd15, 5'd24, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_MS,  7'd20, 4'd6,  5'd15, 5'd31, 6'd10, 6'd10, 32'd77);
        send_reading(MODE_US,  7'd20, 4'd6,  5'd15, 5'd10, 6'd60, 6'd10, 32'd77);
        send_reading(MODE_SEC, 7'd20, 4'd6,  5'd15, 5'd10, 6'd63, 6'd10, 32'd77);
        send_reading(MODE_US,  7'd20, 4'd6,  5'd15, 5'd10, 6'd10, 6'd60, 32'd77);
        send_reading(MODE_SPARE, 7'd20, 4'd6, 5'd15, 5'd10, 6'd10, 6'd63, 32'd77);

        // Hold off the sender until the pipeline has fully emptied once.
        cal_ch.valid <= 1'b0;
        wait_for_results();

        for (int n = 0; n < RANDOM_READINGS; n++) begin
            if (n == RANDOM_READINGS - QUIET_TAIL) begin
                quiet_tail <= 1'b1;
            end
            send_random_reading();
        end
        cal_ch.valid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cte_pkg.sv
hw/rtl/cte_ifs.sv
hw/rtl/cte_date_secs.sv
hw/rtl/cte_frac_mod.sv
hw/rtl/calendar_to_epoch_timestamp.sv
hw/rtl/cte_checker.sv
tb/timestamp_checker.sv
tb/calendar_to_epoch_timestamp_tb.sv
